// ----- hw/rtl/half_step_stepper_positioner_unit_assert.svh -----
// Assertion macros used by the positioner RTL.
`ifndef HALF_STEP_STEPPER_POSITIONER_UNIT_ASSERT_SVH
`define HALF_STEP_STEPPER_POSITIONER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSSP_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HSSP_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/hssp_pkg.sv -----
package hssp_pkg;

  localparam int PHASES  = 8;
  localparam int PHASE_W = $clog2(PHASES);
  localparam int DEG_W   = 10;
  localparam int POS_W   = 14;
  localparam int PER_W   = 8;
  localparam int COIL_W  = 4;
  localparam int CFG_W   = 10;

  // Register indexes on the configuration port.
  localparam logic [0:0] CFG_TARGET_DEGREES    = 1'b0;
  localparam logic [0:0] CFG_STEP_PERIOD_TICKS = 1'b1;

  localparam logic signed [DEG_W-1:0] RESET_TARGET_DEG = 10'sd90;
  localparam logic [PER_W-1:0]        RESET_PERIOD     = 8'd14;

  // Half-step coil patterns by phase; the reverse table mirrors the coil order.
  localparam logic [COIL_W-1:0] FWD_PATTERN [PHASES] =
    '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};
  localparam logic [COIL_W-1:0] REV_PATTERN [PHASES] =
    '{4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9};

  // ceil(512 * 2^15 / 45): exact reciprocal for magnitudes up to 512.
  localparam logic [18:0] STEPS_RECIP = 19'd372828;
  localparam int          RECIP_SHIFT = 15;

  typedef struct packed {
    logic [COIL_W-1:0]       coil;
    logic signed [POS_W-1:0] pos;
    logic [PHASE_W-1:0]      phase;
    logic [PER_W-1:0]        wait_cnt;
  } motion_state_t;

  // Degrees to half steps, degrees * 512 / 45 truncated toward zero.
  function automatic logic signed [POS_W-1:0] deg_to_steps(
    input logic signed [DEG_W-1:0] deg
  );
    logic [DEG_W-1:0]        mag;
    logic [28:0]             prod;
    logic [12:0]             quot;
    logic signed [POS_W-1:0] res;
    mag  = deg[DEG_W-1] ? (~deg + 10'd1) : deg;
    prod = 29'(mag) * 29'(STEPS_RECIP);
    quot = prod[RECIP_SHIFT+12:RECIP_SHIFT];
    res  = $signed({1'b0, quot});
    if (deg[DEG_W-1]) begin
      res = -res;
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/hssp_motion.sv -----
module hssp_motion (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  step_en,
  input  logic signed [hssp_pkg::POS_W-1:0]     goal,
  input  logic [hssp_pkg::PER_W-1:0]            period,
  output hssp_pkg::motion_state_t               state_cur,
  output hssp_pkg::motion_state_t               state_nxt
);

  hssp_pkg::motion_state_t state_r;

  logic                               fwd;
  logic [hssp_pkg::PER_W:0]           wait_inc;
  logic signed [hssp_pkg::POS_W-1:0]  pos_step;

  always_comb begin
    state_nxt = state_r;
    fwd       = goal > state_r.pos;
    wait_inc  = {1'b0, state_r.wait_cnt} + 9'd1;
    pos_step  = fwd ? (state_r.pos + 14'sd1) : (state_r.pos - 14'sd1);
    if (step_en) begin
      if (state_r.pos == goal) begin
        // Parked: coils hold their last pattern.
        state_nxt.phase    = '0;
        state_nxt.wait_cnt = '0;
      end else begin
        state_nxt.coil = fwd ? hssp_pkg::FWD_PATTERN[state_r.phase]
                             : hssp_pkg::REV_PATTERN[state_r.phase];
        if (wait_inc >= {1'b0, period}) begin
          state_nxt.wait_cnt = '0;
          state_nxt.pos      = pos_step;
          state_nxt.phase    = (pos_step == goal) ? '0 : state_r.phase + 3'd1;
        end else begin
          state_nxt.wait_cnt = wait_inc[hssp_pkg::PER_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign state_cur = state_r;

endmodule

// ----- hw/rtl/half_step_stepper_positioner_unit.sv -----
// Half-step stepper positioner.
// The input channel carries one beat per 100 us timer tick (in_tick high means
// time has elapsed; a beat with in_tick low changes nothing). Each input beat
// produces exactly one output beat with the coil drive pattern, the position
// in half steps and an at-target flag, all as they stand after that tick.
// The configuration port writes the target angle in degrees (index 0) and the
// tick count per half step (index 1, zero acts as one). The angle is turned
// into a half-step goal when written, so writes are to be made only while
// idle; the block itself does not enforce this. A beat lands in the input
// register, the motion update runs between that register and the output
// register, and the result is offered from there. Throughput is one beat
// per cycle while the receiver does not stall; hssp_motion computes the next
// motion state combinationally. When the receiver stalls, the result waits in
// the output register and the input register still takes one more beat;
// only then does in_stall rise. Reset (synchronous, active low) clears
// position, phase, wait count and the coil latch, empties both registers,
// and restores a 90 degree target with a period of 14 ticks.
module half_step_stepper_positioner_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_tick,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [hssp_pkg::COIL_W-1:0]          out_coil_bits,
  output logic signed [hssp_pkg::POS_W-1:0]    out_position_steps,
  output logic                                 out_at_target,
  input  logic                                 cfg_wr_en,
  input  logic [0:0]                           cfg_index,
  input  logic [hssp_pkg::CFG_W-1:0]           cfg_data
);

  `include "half_step_stepper_positioner_unit_assert.svh"

  // Configuration: the goal in half steps and the clamped period.
  logic signed [hssp_pkg::POS_W-1:0] goal_r;
  logic [hssp_pkg::PER_W-1:0]        period_r;
  logic [hssp_pkg::PER_W-1:0]        period_wr;

  assign period_wr = cfg_data[hssp_pkg::PER_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_r   <= hssp_pkg::deg_to_steps(hssp_pkg::RESET_TARGET_DEG);
      period_r <= hssp_pkg::RESET_PERIOD;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        hssp_pkg::CFG_TARGET_DEGREES: begin
          goal_r <= hssp_pkg::deg_to_steps($signed(cfg_data));
        end
        hssp_pkg::CFG_STEP_PERIOD_TICKS: begin
          period_r <= (period_wr == '0) ? 8'd1 : period_wr;
        end
        default: begin
        end
      endcase
    end
  end

  // Input register. It moves on whenever the output register is free or
  // is being emptied in this cycle.
  logic s1_valid_r;
  logic s1_tick_r;
  logic s1_move;
  logic in_accept;

  logic out_valid_r;

  assign s1_move   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_move;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_tick_r <= in_tick;
    end
  end

  // Motion state advances only when a ticking beat leaves the input register.
  hssp_pkg::motion_state_t state_cur;
  hssp_pkg::motion_state_t state_nxt;

  hssp_motion u_motion (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s1_move && s1_tick_r),
    .goal      (goal_r),
    .period    (period_r),
    .state_cur (state_cur),
    .state_nxt (state_nxt)
  );

  // Output register.
  logic [hssp_pkg::COIL_W-1:0]       out_coil_r;
  logic signed [hssp_pkg::POS_W-1:0] out_pos_r;
  logic                              out_at_target_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_coil_r      <= state_nxt.coil;
      out_pos_r       <= state_nxt.pos;
      out_at_target_r <= (state_nxt.pos == goal_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_coil_bits      = out_coil_r;
  assign out_position_steps = out_pos_r;
  assign out_at_target      = out_at_target_r;

  // The flag offered with a result agrees with the position it reports.
  `HSSP_CHECK_NOW(a_flag_matches_pos, out_valid_r, out_at_target_r == (out_pos_r == goal_r), "at_target flag disagrees with position")

  // A tick moves the position by at most one half step.
  `HSSP_CHECK_NEXT(a_single_step, s1_move && s1_tick_r, (state_cur.pos == $past(state_cur.pos)) || (state_cur.pos == $past(state_cur.pos) + 14'sd1) || (state_cur.pos == $past(state_cur.pos) - 14'sd1), "position jumped by more than one half step")

  // After a tick that leaves the motor on target, the phase is back at zero.
  `HSSP_CHECK_NEXT(a_phase_parked, s1_move && s1_tick_r, (state_cur.pos != goal_r) || (state_cur.phase == '0), "phase not reset on target")

  // A beat that does not tick leaves the motion state untouched.
  `HSSP_CHECK_NEXT(a_idle_beat_holds, s1_move && !s1_tick_r, state_cur == $past(state_cur), "motion state changed without a tick")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

// Testbench for the half-step stepper positioner.
module tb;

  // One result beat as the block should present it.
  typedef struct packed {
    logic [hssp_pkg::COIL_W-1:0]       coil;
    logic signed [hssp_pkg::POS_W-1:0] pos;
    logic                              at;
  } motor_out_t;

  // Half-step coil patterns by phase. The reverse table is the forward one
  // with the coil order mirrored.
  localparam logic [3:0] FWD_COILS [8] = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};
  localparam logic [3:0] REV_COILS [8] = '{4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9};

  localparam int HOLD_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic                              in_tick = 1'b0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [hssp_pkg::COIL_W-1:0]       out_coil_bits;
  logic signed [hssp_pkg::POS_W-1:0] out_position_steps;
  logic                              out_at_target;
  logic                              cfg_wr_en = 1'b0;
  logic [0:0]                        cfg_index = hssp_pkg::CFG_TARGET_DEGREES;
  logic [hssp_pkg::CFG_W-1:0]        cfg_data = '0;

  // Our own copy of the registers and of the motion state. These follow the
  // block's reset values: a 90 degree target, 14 ticks per half step, and the
  // motor parked at position zero with the coils off.
  int         tgt_deg = 90;
  int         period_ticks = 14;
  int         pos_count = 0;
  int         phase_idx = 0;
  int         wait_ticks = 0;
  logic [3:0] coil_state = 4'h0;

  // Results still owed by the block, oldest first.
  motor_out_t pending[$];
  int         err_count = 0;

  // Idling controls. The sender and the receiver each stall at random about 30
  // percent of the time while their flag is set. A long receiver hold is
  // requested by bumping hold_asks; the receiver process counts it out.
  bit src_gaps = 1'b1;
  bit sink_gaps = 1'b1;
  int hold_asks = 0;
  int hold_served = 0;
  int hold_left = 0;

  half_step_stepper_positioner_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_tick           (in_tick),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_coil_bits     (out_coil_bits),
    .out_position_steps(out_position_steps),
    .out_at_target     (out_at_target),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #6 clk = ~clk;

  // Advances our motion state by one accepted beat and queues the result it
  // should produce. The goal is degrees*512/45 truncated toward zero, which is
  // exactly what signed integer division gives. A period of zero acts as one.
  // A beat without a tick changes nothing and only reports the present state.
  function automatic void advance_motor(input logic tick);
    int         goal;
    int         per;
    bit         fwd;
    motor_out_t r;
    goal = (tgt_deg * 512) / 45;
    per = (period_ticks == 0) ? 1 : period_ticks;
    if (tick) begin
      if (pos_count == goal) begin
        // Parked: the coils keep their last pattern, the sequence restarts.
        phase_idx = 0;
        wait_ticks = 0;
      end else begin
        fwd = goal > pos_count;
        coil_state = fwd ? FWD_COILS[phase_idx] : REV_COILS[phase_idx];
        wait_ticks++;
        // The wait count may already sit above a newly shortened period; the
        // comparison is "at least", so the step is taken at once.
        if (wait_ticks >= per) begin
          wait_ticks = 0;
          pos_count += fwd ? 1 : -1;
          phase_idx = (phase_idx + 1) % 8;
          if (pos_count == goal) begin
            phase_idx = 0;
          end
        end
      end
    end
    r.coil = coil_state;
    r.pos = pos_count[hssp_pkg::POS_W-1:0];
    r.at = (pos_count == goal);
    pending.push_back(r);
  endfunction

  // Result checking and input prediction share one process, so that a result
  // and an accepted beat at the same edge are always handled in that order.
  always @(posedge clk) begin
    motor_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending.size() == 0) begin
          $display("%0t: result beat with none expected: coil %h pos %0d at %b",
                   $time, out_coil_bits, out_position_steps, out_at_target);
          err_count++;
        end else begin
          want = pending.pop_front();
          if (out_coil_bits !== want.coil) begin
            $display("%0t: coil_bits expected %h got %h", $time, want.coil, out_coil_bits);
            err_count++;
          end
          if (out_position_steps !== want.pos) begin
            $display("%0t: position_steps expected %0d got %0d",
                     $time, want.pos, out_position_steps);
            err_count++;
          end
          if (out_at_target !== want.at) begin
            $display("%0t: at_target expected %b got %b", $time, want.at, out_at_target);
            err_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        advance_motor(in_tick);
      end
    end
  end

  // Receiver. A requested hold keeps the stall high while hold_left counts down;
  // otherwise the stall is random while sink_gaps is set.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_asks != hold_served) begin
      hold_served = hold_asks;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= sink_gaps && ($urandom_range(0, 99) < 30);
    end
  end

  // Offers one beat and returns at the edge where the block takes it. Any
  // idle cycles come before valid rises, so valid never reacts to the stall,
  // and the payload holds still for as long as the block stalls.
  task automatic send_beat(input logic tick);
    @(negedge clk);
    while (src_gaps && ($urandom_range(0, 99) < 30)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_tick <= tick;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering beats and waits until every owed result has arrived, then
  // lets the two-stage pipeline empty.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes one register and mirrors it in our copy. Only called while idle.
  task automatic write_reg(input logic [0:0] idx, input int value);
    logic signed [hssp_pkg::DEG_W-1:0] deg;
    logic [hssp_pkg::CFG_W-1:0]        word;
    if (idx == hssp_pkg::CFG_TARGET_DEGREES) begin
      word = value[hssp_pkg::CFG_W-1:0];
    end else begin
      word = {{(hssp_pkg::CFG_W - hssp_pkg::PER_W){1'b0}}, value[hssp_pkg::PER_W-1:0]};
    end
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= word;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == hssp_pkg::CFG_TARGET_DEGREES) begin
      deg = value[hssp_pkg::DEG_W-1:0];
      tgt_deg = deg;
    end else begin
      period_ticks = value[hssp_pkg::PER_W-1:0];
    end
  endtask

  // Short hand-picked sequence: reset values, a beat without a tick, parking
  // at the target, a zero period, a full move to a small target, the register
  // extremes, and a reverse move started with a wait count above the period.
  task automatic test_directed_cases();
    // Reset configuration: a 90 degree target at 14 ticks per half step.
    send_beat(1'b0);
    send_beat(1'b1);
    send_beat(1'b1);
    settle();
    // A zero target while at position zero: the coils just hold.
    write_reg(hssp_pkg::CFG_STEP_PERIOD_TICKS, 0);
    write_reg(hssp_pkg::CFG_TARGET_DEGREES, 0);
    send_beat(1'b1);
    settle();
    // One degree is eleven half steps; with the zero period taken as one
    // tick the move ends after eleven ticks and the twelfth parks.
    write_reg(hssp_pkg::CFG_TARGET_DEGREES, 1);
    repeat (12) send_beat(1'b1);
    settle();
    // Largest positive target and longest period.
    write_reg(hssp_pkg::CFG_TARGET_DEGREES, 511);
    write_reg(hssp_pkg::CFG_STEP_PERIOD_TICKS, 255);
    send_beat(1'b1);
    send_beat(1'b0);
    send_beat(1'b1);
    settle();
    // Most negative target, reverse patterns, one tick per half step.
    write_reg(hssp_pkg::CFG_TARGET_DEGREES, -512);
    write_reg(hssp_pkg::CFG_STEP_PERIOD_TICKS, 1);
    repeat (3) send_beat(1'b1);
    settle();
  endtask

  // Random moves. Each round picks new settings, mostly a target a few
  // degrees from where the motor stands so that moves finish and park, and
  // now and then one of the far extremes. Periods are mostly short, with a
  // few long ones. About one beat in ten carries no tick.
  task automatic test_random_moves(input int n_beats);
    int sent;
    int len;
    int here_deg;
    int tgt;
    int pick;
    sent = 0;
    while (sent < n_beats) begin
      settle();
      pick = $urandom_range(0, 99);
      here_deg = (pos_count * 45) / 512;
      if (pick < 3) begin
        tgt = -512;
      end else if (pick < 6) begin
        tgt = 511;
      end else if (pick < 8) begin
        tgt = ($urandom_range(0, 1) != 0) ? 360 : -360;
      end else begin
        tgt = here_deg + $urandom_range(0, 6) - 3;
      end
      if (tgt > 511) begin
        tgt = 511;
      end
      if (tgt < -512) begin
        tgt = -512;
      end
      if ($urandom_range(0, 9) < 8) begin
        write_reg(hssp_pkg::CFG_TARGET_DEGREES, tgt);
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        write_reg(hssp_pkg::CFG_STEP_PERIOD_TICKS, $urandom_range(0, 2));
      end else if (pick < 80) begin
        write_reg(hssp_pkg::CFG_STEP_PERIOD_TICKS, $urandom_range(3, 8));
      end else if (pick < 92) begin
        write_reg(hssp_pkg::CFG_STEP_PERIOD_TICKS, $urandom_range(9, 40));
      end else if (pick < 96) begin
        write_reg(hssp_pkg::CFG_STEP_PERIOD_TICKS, $urandom_range(200, 255));
      end
      len = $urandom_range(15, 60);
      repeat (len) send_beat($urandom_range(0, 9) != 0);
      sent += len;
    end
  endtask

  // A long stretch at full rate on both sides, one tick per beat.
  task automatic test_back_to_back();
    settle();
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    write_reg(hssp_pkg::CFG_STEP_PERIOD_TICKS, 1);
    write_reg(hssp_pkg::CFG_TARGET_DEGREES, ((pos_count * 45) / 512 > 0) ? -4 : 4);
    repeat (100) send_beat(1'b1);
    settle();
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering beats, so the block fills up and stalls its input. The sender
  // then pauses until every result has come back.
  task automatic test_backpressure();
    settle();
    write_reg(hssp_pkg::CFG_STEP_PERIOD_TICKS, 2);
    write_reg(hssp_pkg::CFG_TARGET_DEGREES, (pos_count >= 0) ? -2 : 2);
    src_gaps = 1'b0;
    @(posedge clk);
    hold_asks++;
    repeat (40) send_beat(1'b1);
    settle();
    src_gaps = 1'b1;
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_random_moves(380);
    test_back_to_back();
    test_backpressure();
    test_random_moves(360);
    settle();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5000000;
    $display("tb: errors");
    $finish;
  end

endmodule

// ----- half_step_stepper_positioner_unit.f -----
+incdir+hw/rtl
hw/rtl/hssp_pkg.sv
hw/rtl/hssp_motion.sv
hw/rtl/half_step_stepper_positioner_unit.sv
tb/tb.sv
